// ----- rtl/swmm_pkg.sv -----
// Shared types and constants for the sliding window median and mean unit.
package swmm_pkg;

    // Result format: signed Q16.8 on a 24-bit port.
    localparam int OUT_WIDTH = 24;
    localparam int FRAC_BITS = 8;

    // Configuration port geometry and register map.
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEAN_MODE   = 1'b1;

    localparam logic [CFG_DATA_W-1:0] WINDOW_SIZE_RESET = 7'd1;

    // Quotient bits the mean divider resolves in one clock.
    localparam int DIV_STEP_BITS = 4;

    // Command broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic clear;
        logic del;
        logic ins;
    } swmm_cell_cmd_t;

endpackage

// ----- rtl/swmm_cell.sv -----
// One cell of the sorted sample chain: holds one value and shifts with its neighbours.
module swmm_cell #(
    parameter int SW  = 16,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  swmm_pkg::swmm_cell_cmd_t        cmd,
    input  logic signed [SW-1:0]            s,
    input  logic signed [SW-1:0]            x,
    input  logic signed [SW-1:0]            left_val,
    input  logic                            left_valid,
    input  logic signed [SW-1:0]            right_val,
    input  logic                            right_valid,
    input  logic [CW-1:0]                   lo_idx,
    input  logic [CW-1:0]                   hi_idx,
    output logic signed [SW-1:0]            val,
    output logic                            valid,
    output logic [SW-1:0]                   lo_tap,
    output logic [SW-1:0]                   hi_tap
);
    import swmm_pkg::*;

    logic signed [SW-1:0] val_reg;
    logic signed [SW-1:0] val_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 left_gt;
    logic                 self_gt;

    // Empty cells sit at the top of the chain and count as larger than any sample.
    assign left_gt = (IDX != 0) && (!left_valid || (left_val > s));
    assign self_gt = !valid_reg || (val_reg > s);

    // Deletion removes the first cell equal to the evicted sample; equal values are
    // kept oldest first, so that cell is the oldest one. Insertion puts a new sample
    // after all cells that are not larger than it.
    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        priority if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.del)
        begin
            if (valid_reg && (val_reg >= x))
            begin
                val_next   = right_val;
                valid_next = right_valid;
            end
        end
        else if (cmd.ins)
        begin
            if (left_gt)
            begin
                val_next   = left_val;
                valid_next = left_valid;
            end
            else if (self_gt)
            begin
                val_next   = s;
                valid_next = 1'b1;
            end
        end
        else
        begin
            // No command: the cell keeps its contents.
            val_next   = val_reg;
            valid_next = valid_reg;
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored value.
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

    // Taps for the two middle ranks of the window.
    assign lo_tap = (valid_reg && (CW'(IDX) == lo_idx)) ? val_reg : '0;
    assign hi_tap = (valid_reg && (CW'(IDX) == hi_idx)) ? val_reg : '0;

endmodule

// ----- rtl/swmm_div.sv -----
// Unsigned restoring divider that resolves a few quotient bits per clock.
module swmm_div #(
    parameter int DW = 31,
    parameter int VW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    import swmm_pkg::*;

    localparam int ITER = (DW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int DP   = ITER * DIV_STEP_BITS;
    localparam int CNW  = $clog2(ITER + 1);

    logic [DP-1:0]  q_reg;
    logic [DP-1:0]  q_next;
    logic [VW-1:0]  rem_reg;
    logic [VW-1:0]  rem_next;
    logic [CNW-1:0] cnt_reg;
    logic [CNW-1:0] cnt_next;
    logic           done_reg;
    logic           done_next;
    logic [DP-1:0]  q_step;
    logic [VW-1:0]  rem_step;

    // A group of restoring steps: the dividend shifts out at the top of q while
    // quotient bits shift in at the bottom.
    always_comb
    begin
        logic [VW:0] rem_w;
        q_step   = q_reg;
        rem_step = rem_reg;
        for (int k = 0; k < DIV_STEP_BITS; k++)
        begin
            rem_w  = {rem_step, q_step[DP-1]};
            q_step = {q_step[DP-2:0], 1'b0};
            if (rem_w >= {1'b0, divisor})
            begin
                rem_w     = rem_w - {1'b0, divisor};
                q_step[0] = 1'b1;
            end
            rem_step = rem_w[VW-1:0];
        end
    end

    // Iteration control.
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (start)
        begin
            q_next    = DP'(dividend);
            rem_next  = '0;
            cnt_next  = CNW'(ITER);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            q_next   = q_step;
            rem_next = rem_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNW'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg[DW-1:0];

endmodule

// ----- rtl/sliding_window_median_mean_unit.sv -----
// Top level of the sliding window median and mean unit.
//
//  channel   direction  handshake            payload
//  cfg       in         cfg_we               cfg_index, cfg_data
//  in        in         in_valid / in_stall  sample
//  out       out        out_valid / out_stall filtered
//
// While the window fills, a sample passes through the insert step and gives
// no result unless it completes the window. Once full, a median result
// takes store read, delete of the oldest sample from the sorted cell chain,
// insert of the new one and tap select. A mean result adds ceil((SAMPLE_WIDTH
// + clog2(MAX_WINDOW) + 9) / 4) divider steps and a check of the done flag.
// Reset and any configuration write empty the window. A stalled output holds
// its transfer while the next sample is already taken in.
module sliding_window_median_mean_unit #(
    parameter int MAX_WINDOW   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [swmm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [swmm_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]          sample,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [swmm_pkg::OUT_WIDTH-1:0]   filtered
);
    import swmm_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUMW = SW + $clog2(MAX_WINDOW) + 1;
    localparam int DW   = SUMW + FRAC_BITS;
    localparam int MW   = SW + FRAC_BITS;
    localparam int EW0  = (MW + 1 > DW + 2) ? MW + 1 : DW + 2;
    localparam int EW   = (EW0 > OUT_WIDTH + 1) ? EW0 : OUT_WIDTH + 1;

    localparam logic signed [EW-1:0] SAT_HI = EW'((2 ** (OUT_WIDTH - 1)) - 1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DEL  = 5'b00010,
        ST_INS  = 5'b00100,
        ST_SEL  = 5'b01000,
        ST_DIV  = 5'b10000
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [CFG_DATA_W-1:0]      window_size_reg;
    logic [CFG_DATA_W-1:0]      window_size_next;
    logic                       mean_mode_reg;
    logic                       mean_mode_next;
    logic [CW-1:0]              fill_count_reg;
    logic [CW-1:0]              fill_count_next;
    logic [AW-1:0]              oldest_slot_reg;
    logic [AW-1:0]              oldest_slot_next;
    logic                       full_item_reg;
    logic                       full_item_next;
    logic signed [SUMW-1:0]     sum_reg;
    logic signed [SUMW-1:0]     sum_next;
    logic                       sign_reg;
    logic                       sign_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [OUT_WIDTH-1:0] filtered_reg;
    logic signed [OUT_WIDTH-1:0] filtered_next;
    logic signed [SW-1:0]       s_reg;
    logic signed [SW-1:0]       x_reg;

    logic signed [SW-1:0]       mem [MAX_WINDOW];
    logic                       mem_we;
    logic [AW-1:0]              mem_addr;

    logic [CW-1:0]              win_n;
    logic [CW-1:0]              lo_idx;
    logic [CW-1:0]              hi_idx;
    logic                       in_accept;
    logic                       cfg_hit;
    logic                       slot_free;
    swmm_cell_cmd_t             cmd;

    logic signed [SW-1:0]       cell_val [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]      cell_valid;
    logic [SW-1:0]              cell_lo [MAX_WINDOW];
    logic [SW-1:0]              cell_hi [MAX_WINDOW];
    logic [SW-1:0]              lo_or;
    logic [SW-1:0]              hi_or;
    logic signed [SW:0]         pair_sum;
    logic signed [MW-1:0]       med_fix;
    logic signed [OUT_WIDTH-1:0] med_result;
    logic signed [OUT_WIDTH-1:0] mean_result;
    logic signed [EW-1:0]       q_ext;
    logic signed [EW-1:0]       mean_ext;

    logic [SUMW-1:0]            sum_mag;
    logic [DW-1:0]              div_dividend;
    logic [DW-1:0]              div_quot;
    logic                       div_start;
    logic                       div_done;

    // Clamp a wide signed value to the output range.
    function automatic logic signed [OUT_WIDTH-1:0] sat_out(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[OUT_WIDTH-1:0];
    endfunction

    // Effective window length: zero counts as one, large sizes saturate.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_n = CW'(1);
        end
        else if (32'(window_size_reg) > 32'(MAX_WINDOW))
        begin
            win_n = CW'(MAX_WINDOW);
        end
        else
        begin
            win_n = CW'(window_size_reg);
        end
    end

    // Ranks of the two middle samples; they coincide for an odd window.
    assign lo_idx = (win_n - 1'b1) >> 1;
    assign hi_idx = win_n >> 1;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_hit   = cfg_we && ((cfg_index == REG_WINDOW_SIZE) || (cfg_index == REG_MEAN_MODE));
    assign slot_free = !out_valid_reg || !out_stall;

    // Sorted cell chain.
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        localparam int  LI   = (i == 0) ? 0 : i - 1;
        localparam int  RI   = (i == MAX_WINDOW - 1) ? i : i + 1;
        localparam bit  LAST = (i == MAX_WINDOW - 1);

        swmm_cell #(
            .SW  (SW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .s           (s_reg),
            .x           (x_reg),
            .left_val    (cell_val[LI]),
            .left_valid  (cell_valid[LI]),
            .right_val   (cell_val[RI]),
            .right_valid (LAST ? 1'b0 : cell_valid[RI]),
            .lo_idx      (lo_idx),
            .hi_idx      (hi_idx),
            .val         (cell_val[i]),
            .valid       (cell_valid[i]),
            .lo_tap      (cell_lo[i]),
            .hi_tap      (cell_hi[i])
        );
    end

    // Gather the middle taps; exactly one cell drives each.
    always_comb
    begin
        lo_or = '0;
        hi_or = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            lo_or = lo_or | cell_lo[i];
            hi_or = hi_or | cell_hi[i];
        end
    end

    // Median: (lo + hi) / 2 in Q.8, which is exact.
    assign pair_sum   = {lo_or[SW-1], lo_or} + {hi_or[SW-1], hi_or};
    assign med_fix    = {pair_sum, {(FRAC_BITS - 1){1'b0}}};
    assign med_result = sat_out(EW'(med_fix));

    // Mean: magnitude of sum * 256 divided by the window length, sign put back.
    assign sum_mag      = sum_reg[SUMW-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign div_dividend = {sum_mag, {FRAC_BITS{1'b0}}};
    assign q_ext        = EW'(div_quot);
    assign mean_ext     = sign_reg ? -q_ext : q_ext;
    assign mean_result  = sat_out(mean_ext);

    swmm_div #(
        .DW (DW),
        .VW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (win_n),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        mean_mode_next   = mean_mode_reg;
        fill_count_next  = fill_count_reg;
        oldest_slot_next = oldest_slot_reg;
        full_item_next   = full_item_reg;
        sum_next         = sum_reg;
        sign_next        = sign_reg;
        filtered_next    = filtered_reg;
        out_valid_next   = out_valid_reg && out_stall;
        cmd              = '0;
        div_start        = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = oldest_slot_reg;

        if (cfg_hit)
        begin
            // Any register write empties the window.
            if (cfg_index == REG_WINDOW_SIZE)
            begin
                window_size_next = cfg_data;
            end
            else
            begin
                mean_mode_next = cfg_data[0];
            end
            fill_count_next  = '0;
            oldest_slot_next = '0;
            sum_next         = '0;
            cmd.clear        = 1'b1;
            state_next       = ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        full_item_next = (fill_count_reg == win_n);
                        state_next     = (fill_count_reg == win_n) ? ST_DEL : ST_INS;
                    end
                end
                ST_DEL:
                begin
                    // Evict the oldest sample and reuse its store slot.
                    cmd.del  = 1'b1;
                    mem_we   = 1'b1;
                    mem_addr = oldest_slot_reg;
                    sum_next = sum_reg - SUMW'(x_reg);
                    if ((CW'(oldest_slot_reg) + 1'b1) == win_n)
                    begin
                        oldest_slot_next = '0;
                    end
                    else
                    begin
                        oldest_slot_next = oldest_slot_reg + 1'b1;
                    end
                    state_next = ST_INS;
                end
                ST_INS:
                begin
                    cmd.ins  = 1'b1;
                    sum_next = sum_reg + SUMW'(s_reg);
                    if (!full_item_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_addr        = fill_count_reg[AW-1:0];
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                    if (full_item_reg || (CW'(fill_count_reg + 1'b1) == win_n))
                    begin
                        state_next = ST_SEL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_SEL:
                begin
                    if (mean_mode_reg)
                    begin
                        div_start  = 1'b1;
                        sign_next  = sum_reg[SUMW-1];
                        state_next = ST_DIV;
                    end
                    else if (slot_free)
                    begin
                        filtered_next  = med_result;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    if (div_done && slot_free)
                    begin
                        filtered_next  = mean_result;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WINDOW_SIZE_RESET;
            mean_mode_reg   <= 1'b0;
            fill_count_reg  <= '0;
            oldest_slot_reg <= '0;
            full_item_reg   <= 1'b0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            mean_mode_reg   <= mean_mode_next;
            fill_count_reg  <= fill_count_next;
            oldest_slot_reg <= oldest_slot_next;
            full_item_reg   <= full_item_next;
            sum_reg         <= sum_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sign_reg     <= sign_next;
        filtered_reg <= filtered_next;
        if (in_accept)
        begin
            s_reg <= sample;
        end
    end

    // Sample store in arrival order; the oldest entry is read as a sample is taken.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= s_reg;
        end
        if (in_accept)
        begin
            x_reg <= mem[oldest_slot_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // The fill level never passes the window length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= win_n)
        else $error("fill count beyond window length");

    // The replacement slot always lies inside the window.
    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(oldest_slot_reg) < win_n)
        else $error("oldest slot outside window");

    // When a result is picked, the chain holds exactly one full window.
    a_chain_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL) |-> ($countones(cell_valid) == int'(win_n)))
        else $error("cell chain occupancy differs from window length");

    // A result only appears out of the select or divide step.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_SEL || $past(state_reg) == ST_DIV))
        else $error("result raised outside select or divide");

endmodule

// ----- test/sliding_window_median_mean_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sliding window median and mean unit.
module sliding_window_median_mean_unit_test;
    import swmm_pkg::*;

    localparam int MAX_WINDOW    = 64;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CORNER_PHASES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam longint OUT_MAX   = (longint'(1) <<< (OUT_WIDTH - 1)) - 1;
    localparam longint OUT_MIN   = -OUT_MAX - 1;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [CFG_INDEX_W-1:0]              cfg_index;
    logic [CFG_DATA_W-1:0]               cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [SAMPLE_WIDTH-1:0]      sample;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [OUT_WIDTH-1:0]         filtered;

    // Shadow copy of the registers and the sample window.
    logic [CFG_DATA_W-1:0]               window_reg;
    logic                                mean_reg;
    logic signed [SAMPLE_WIDTH-1:0]      window_store [MAX_WINDOW];
    int unsigned                         oldest_slot;
    int unsigned                         fill_count;

    // Filtered values still owed by the block, oldest first.
    logic signed [OUT_WIDTH-1:0]         pending_results [$];

    int unsigned                         mismatches = 0;
    int unsigned                         cycle_count = 0;
    bit                                  idle_off = 1'b0;

    sliding_window_median_mean_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (idle_off)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 15);
    endfunction

    // A window size of zero acts as one and anything above the store saturates.
    function automatic int unsigned window_len();
        if (window_reg == 0)
            return 1;
        if (window_reg > MAX_WINDOW)
            return MAX_WINDOW;
        return window_reg;
    endfunction

    // Median or truncated mean of the first n stored samples, in Q16.8.
    function automatic logic signed [OUT_WIDTH-1:0] filter_value(int unsigned n);
        longint sorted_vals [MAX_WINDOW];
        longint acc;
        longint v;
        int     j;
        if (mean_reg)
        begin
            acc = 0;
            for (int i = 0; i < n; i++)
                acc += window_store[i];
            acc = (acc * (longint'(1) <<< FRAC_BITS)) / longint'(n);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                v = window_store[i];
                j = i;
                while (j > 0 && sorted_vals[j-1] > v)
                begin
                    sorted_vals[j] = sorted_vals[j-1];
                    j--;
                end
                sorted_vals[j] = v;
            end
            // An even window averages the two middle values, which is exact at half scale.
            if (n % 2 == 0)
                acc = (sorted_vals[n/2-1] + sorted_vals[n/2]) * (longint'(1) <<< (FRAC_BITS - 1));
            else
                acc = sorted_vals[n/2] * (longint'(1) <<< FRAC_BITS);
        end
        if (acc > OUT_MAX)
            acc = OUT_MAX;
        if (acc < OUT_MIN)
            acc = OUT_MIN;
        return acc[OUT_WIDTH-1:0];
    endfunction

    // Update the shadow window with an accepted sample and queue any result.
    function automatic void record_sample(logic signed [SAMPLE_WIDTH-1:0] s);
        int unsigned n;
        n = window_len();
        if (fill_count > n || oldest_slot >= n)
        begin
            fill_count  = 0;
            oldest_slot = 0;
        end
        if (fill_count < n)
        begin
            window_store[fill_count] = s;
            fill_count++;
            if (fill_count < n)
                return;
        end
        else
        begin
            window_store[oldest_slot] = s;
            oldest_slot = (oldest_slot + 1 == n) ? 0 : oldest_slot + 1;
        end
        pending_results.insert(pending_results.size(), filter_value(n));
    endfunction

    // Mix of extremes, a narrow band that forces ties, and the full range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        if (r < 45)
            return SAMPLE_WIDTH'(int'($urandom_range(8)) - 4);
        return SAMPLE_WIDTH'($urandom);
    endfunction

    // Offer one sample; called and returning at a falling edge.
    task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] v);
        int unsigned gap;
        in_valid = 1'b1;
        sample   = v;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        record_sample(v);
        @(negedge clk);
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid = 1'b0;
            sample   = SAMPLE_WIDTH'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Let every owed result drain and any fill-only work finish.
    task automatic settle();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        if (idx == REG_WINDOW_SIZE)
            window_reg = data;
        else if (idx == REG_MEAN_MODE)
            mean_reg = data[0];
        // Any register write empties the window.
        fill_count  = 0;
        oldest_slot = 0;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mode writes carry random upper bits, which the block must ignore.
    task automatic configure(int unsigned win, bit mean);
        logic [CFG_DATA_W-1:0] mode_word;
        settle();
        write_reg(REG_WINDOW_SIZE, CFG_DATA_W'(win));
        mode_word    = CFG_DATA_W'($urandom);
        mode_word[0] = mean;
        write_reg(REG_MEAN_MODE, mode_word);
    endtask

    // Out of reset the window holds one sample, so each one returns scaled.
    task automatic check_default_window();
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'haaaa);
    endtask

    // Even windows average the middle pair; odd ones take the centre value.
    task automatic check_median_windows();
        configure(4, 1'b0);
        send_sample(5);
        send_sample(-3);
        send_sample(7);
        send_sample(7);
        send_sample(1);
        configure(3, 1'b0);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(0);
        send_sample(-1);
        configure(2, 1'b0);
        send_sample(16'h8000);
        send_sample(16'h7fff);
    endtask

    // Negative means truncate toward zero; a zero window acts as one.
    task automatic check_mean_windows();
        configure(3, 1'b1);
        send_sample(-1);
        send_sample(-1);
        send_sample(0);
        send_sample(2);
        configure(0, 1'b1);
        send_sample(16'h7fff);
        send_sample(16'h8000);
    endtask

    // Corner settings first, then random settings with mostly small windows.
    task automatic check_random_streams();
        int unsigned corner_windows [CORNER_PHASES] = '{1, 0, 2, 2, 127, 64, 65, 63};
        bit          corner_modes   [CORNER_PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0};
        int unsigned phase;
        int unsigned sent;
        int unsigned count;
        int unsigned win;
        int unsigned r;
        bit          mean;
        phase = 0;
        sent  = 0;
        while (phase < CORNER_PHASES || sent < RANDOM_ITEMS)
        begin
            if (phase < CORNER_PHASES)
            begin
                win  = corner_windows[phase];
                mean = corner_modes[phase];
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 80)
                    win = $urandom_range(12, 1);
                else if (r < 95)
                    win = $urandom_range(64, 13);
                else
                    win = $urandom_range(127);
                mean = $urandom_range(1);
            end
            idle_off = ($urandom_range(3) == 0);
            configure(win, mean);
            count = window_len() + $urandom_range(24, 3);
            repeat (count) send_sample(random_sample());
            sent += count;
            phase++;
        end
        idle_off = 1'b0;
    endtask

    // Output stall pattern: bursts of stall separated by free stretches.
    initial
    begin : stall_pattern
        int unsigned hold;
        out_stall = 1'b0;
        forever
        begin
            hold = idle_len();
            repeat (hold)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            hold = $urandom_range(8, 1);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Compare every result transfer with the oldest owed value.
    always @(posedge clk)
    begin : result_check
        logic signed [OUT_WIDTH-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transfer: filtered %0d", filtered);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (filtered !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("filtered mismatch: expected %0d, got %0d", want, filtered);
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_WINDOW_SIZE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        sample      = '0;
        window_reg  = WINDOW_SIZE_RESET;
        mean_reg    = 1'b0;
        fill_count  = 0;
        oldest_slot = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        check_default_window();
        check_median_windows();
        check_mean_windows();
        check_random_streams();
        settle();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
